// File: hw/rtl/amcd_pkg.sv
// Package for the AVI MJPEG chunk demultiplexer: parse phases, result and status codes,
// chunk tag constants and the helper functions for padding and argument checks.
// No dependencies.
`default_nettype none

package amcd_pkg;

   typedef enum logic [2:0] {
      PH_STOPPED,
      PH_RIFF,
      PH_CHDR,
      PH_LNAME,
      PH_ARGS,
      PH_DHDR,
      PH_PAYLOAD,
      PH_SKIP
   } phase_type;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_HEADER  = 2'd1;
   localparam logic [1:0] KIND_STOP    = 2'd2;

   localparam logic [1:0] SK_OTHER = 2'd0;
   localparam logic [1:0] SK_VIDEO = 2'd1;
   localparam logic [1:0] SK_AUDIO = 2'd2;

   localparam logic [2:0] ST_EOF_HDR   = 3'd0;
   localparam logic [2:0] ST_NOT_AVI   = 3'd1;
   localparam logic [2:0] ST_BAD_CODEC = 3'd2;
   localparam logic [2:0] ST_TOO_BIG   = 3'd3;
   localparam logic [2:0] ST_READ_ERR  = 3'd4;
   localparam logic [2:0] ST_EOF_DATA  = 3'd5;

   localparam int unsigned ARG_WORDS     = 7;
   localparam logic [31:0] KEPT_ARG_BYTES = 32'd28;
   localparam logic [31:0] RIFF_HDR_BYTES = 32'd12;
   localparam logic [31:0] MAX_FRAME_RESET = 32'd65536;

   localparam int unsigned RSP_DATA_BITS = 144;

   // Four-character codes as little-endian words.
   localparam logic [31:0] FCC_RIFF = 32'h4646_4952;
   localparam logic [31:0] FCC_AVI  = 32'h2049_5641;
   localparam logic [31:0] FCC_LIST = 32'h5453_494C;
   localparam logic [31:0] FCC_MOVI = 32'h6976_6F6D;
   localparam logic [31:0] FCC_VIDS = 32'h7364_6976;
   localparam logic [31:0] FCC_AUDS = 32'h7364_7561;
   localparam logic [31:0] FCC_MJPG_U = 32'h4750_4A4D;
   localparam logic [31:0] FCC_MJPG_L = 32'h6770_6A6D;
   localparam logic [31:0] FCC_MSVC_U = 32'h4356_534D;
   localparam logic [31:0] FCC_MSVC_L = 32'h6376_736D;
   localparam logic [31:0] FCC_CRAM_U = 32'h4D41_5243;
   localparam logic [31:0] FCC_CRAM_L = 32'h6D61_7263;
   localparam logic [31:0] FCC_STRH = 32'h6872_7473;
   localparam logic [31:0] FCC_STRF = 32'h6672_7473;
   localparam logic [31:0] FCC_00DB = 32'h6264_3030;
   localparam logic [31:0] FCC_00DC = 32'h6364_3030;

   typedef struct packed {
      logic       ok;
      logic [1:0] kind;
      logic       keep_rate;
      logic       keep_dims;
   } fin_type;

   // Odd lengths round up to even; the all-ones length saturates.
   function automatic logic [31:0] pad_len(input logic [31:0] n);
      logic [31:0] r;
      r = n;
      if (n[0] && (n != '1)) begin
         r = n + 32'd1;
      end
      return r;
   endfunction

   function automatic fin_type finish_args(input logic [31:0] tag,
                                           input logic [31:0] w0,
                                           input logic [31:0] w1,
                                           input logic [31:0] w4,
                                           input logic [1:0]  kind);
      fin_type f;
      f.ok        = 1'b1;
      f.kind      = kind;
      f.keep_rate = 1'b0;
      f.keep_dims = 1'b0;
      if (tag == FCC_STRH) begin
         if (w0 == FCC_VIDS) begin
            if (w1 inside {FCC_MJPG_U, FCC_MJPG_L, FCC_MSVC_U, FCC_MSVC_L}) begin
               f.keep_rate = 1'b1;
               f.kind      = SK_VIDEO;
            end else begin
               f.ok = 1'b0;
            end
         end else if (w0 == FCC_AUDS) begin
            f.kind = SK_AUDIO;
         end
      end else if (tag == FCC_STRF) begin
         if (kind == SK_VIDEO) begin
            f.keep_dims = 1'b1;
            f.ok = w4 inside {FCC_MJPG_U, FCC_MJPG_L, FCC_MSVC_U, FCC_MSVC_L,
                              FCC_CRAM_U, FCC_CRAM_L};
         end
      end else begin
         f.kind = SK_OTHER;
      end
      return f;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/avi_mjpeg_chunk_demux_top.sv
// AVI MJPEG chunk demultiplexer. An accepted input word passes through the input register
// and then the result register, from which its result word is offered.
// Throughput: one file byte per cycle while the result side keeps up.
// Reset: the parser is stopped until a word with new_file set arrives; the frame size
// limit returns to 65536.
// Depends on amcd_pkg.
`default_nettype none

module avi_mjpeg_chunk_demux_top #(
   parameter int unsigned ARG_CAPTURE_BYTES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration: largest padded video chunk length.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data,
   // Input stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // file_byte
   input  wire logic        req_tuser,   // new_file
   input  wire logic        req_tlast,   // end_of_file
   // Result stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // payload_byte, frame_length, status_code, frame_width, frame_height,
   // rate_value, scale_value, then zero fill
   output logic [amcd_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [1:0]       rsp_tuser,   // result_kind
   output logic             rsp_tlast    // last_of_frame
);
   import amcd_pkg::*;

   // Input register.
   logic        in_valid_ff;
   logic        nf_ff;
   logic [7:0]  byte_ff;
   logic        eof_ff;

   // Parser state.
   phase_type   phase_ff, phase_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] words_ff [ARG_WORDS];
   logic [31:0] words_in [ARG_WORDS];
   logic [1:0]  skind_ff, skind_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] scale_ff, scale_in;
   logic [31:0] max_ff;

   // Result register.
   logic        rsp_valid_ff, res_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic        last_ff, last_in;
   logic [7:0]  pbyte_ff, pbyte_in;
   logic [31:0] flen_ff, flen_in;
   logic [2:0]  status_ff, status_in;
   logic [15:0] owidth_ff, owidth_in;
   logic [15:0] oheight_ff, oheight_in;
   logic [31:0] orate_ff, orate_in;
   logic [31:0] oscale_ff, oscale_in;

   logic        go;

   // Effective state for this word: a new file starts from cleared state.
   phase_type   cur_phase;
   logic [31:0] cur_cnt, cur_tag, cur_len;
   logic [31:0] cur_words [ARG_WORDS];
   logic [1:0]  cur_skind;
   logic [15:0] cur_width, cur_height;
   logic [31:0] cur_rate, cur_scale;

   logic [31:0] cnt_inc, tag_sh, len_sh, hdr_len_pad;
   logic        cnt_lt4, riff_done, riff_ok, hdr_done, name_done, is_movi;
   logic        args_done, run_done, is_video_tag, too_big;
   logic [31:0] words_upd [ARG_WORDS];
   logic [31:0] fin_words [ARG_WORDS];
   fin_type     fin;

   assign go         = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || go;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         nf_ff   <= req_tuser;
         byte_ff <= req_tdata;
         eof_ff  <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_FRAME_RESET;
      end else if (csr_valid) begin
         max_ff <= csr_data;
      end
   end

   always_comb begin
      cur_phase  = nf_ff ? PH_RIFF : phase_ff;
      cur_cnt    = nf_ff ? '0 : cnt_ff;
      cur_tag    = nf_ff ? '0 : tag_ff;
      cur_len    = nf_ff ? '0 : len_ff;
      cur_skind  = nf_ff ? SK_OTHER : skind_ff;
      cur_width  = nf_ff ? '0 : width_ff;
      cur_height = nf_ff ? '0 : height_ff;
      cur_rate   = nf_ff ? '0 : rate_ff;
      cur_scale  = nf_ff ? '0 : scale_ff;
      for (int i = 0; i < ARG_WORDS; i++) begin
         cur_words[i] = nf_ff ? '0 : words_ff[i];
      end
   end

   assign cnt_inc     = cur_cnt + 32'd1;
   assign tag_sh      = {byte_ff, cur_tag[31:8]};
   assign len_sh      = {byte_ff, cur_len[31:8]};
   assign cnt_lt4     = cur_cnt < 32'd4;
   assign riff_done   = cnt_inc == RIFF_HDR_BYTES;
   // The tag is complete before the last length byte arrives.
   assign riff_ok     = (cur_tag == FCC_RIFF) && (len_sh == FCC_AVI);
   assign hdr_done    = cur_cnt == 32'd7;
   assign hdr_len_pad = pad_len(len_sh);
   assign name_done   = cur_cnt == 32'd3;
   assign is_movi     = len_sh == FCC_MOVI;
   assign args_done   = cnt_inc == cur_len;
   assign run_done    = cnt_inc == cur_len;
   assign is_video_tag = (cur_tag == FCC_00DB) || (cur_tag == FCC_00DC);
   assign too_big     = hdr_len_pad > max_ff;

   // Only the first seven words of an argument chunk are kept.
   always_comb begin
      for (int i = 0; i < ARG_WORDS; i++) begin
         words_upd[i] = cur_words[i];
      end
      if ((cur_cnt < KEPT_ARG_BYTES) && (cur_cnt < 32'(ARG_CAPTURE_BYTES))) begin
         words_upd[cur_cnt[4:2]][cur_cnt[1:0]*8 +: 8] = byte_ff;
      end
      for (int i = 0; i < ARG_WORDS; i++) begin
         fin_words[i] = (cur_phase == PH_ARGS) ? words_upd[i] : '0;
      end
   end

   assign fin = finish_args(cur_tag, fin_words[0], fin_words[1], fin_words[4], cur_skind);

   // Next state of the parser.
   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      tag_in    = tag_ff;
      len_in    = len_ff;
      skind_in  = skind_ff;
      width_in  = width_ff;
      height_in = height_ff;
      rate_in   = rate_ff;
      scale_in  = scale_ff;
      for (int i = 0; i < ARG_WORDS; i++) begin
         words_in[i] = words_ff[i];
      end
      if (go) begin
         phase_in  = cur_phase;
         cnt_in    = cur_cnt;
         tag_in    = cur_tag;
         len_in    = cur_len;
         skind_in  = cur_skind;
         width_in  = cur_width;
         height_in = cur_height;
         rate_in   = cur_rate;
         scale_in  = cur_scale;
         for (int i = 0; i < ARG_WORDS; i++) begin
            words_in[i] = cur_words[i];
         end
         if (cur_phase != PH_STOPPED) begin
            if (eof_ff) begin
               phase_in = PH_STOPPED;
               cnt_in   = '0;
            end else begin
               case (cur_phase)
                  PH_RIFF: begin
                     if (cnt_lt4) tag_in = tag_sh;
                     else         len_in = len_sh;
                     cnt_in = cnt_inc;
                     if (riff_done) begin
                        cnt_in   = '0;
                        phase_in = riff_ok ? PH_CHDR : PH_STOPPED;
                     end
                  end
                  PH_CHDR, PH_DHDR: begin
                     if (cnt_lt4) tag_in = tag_sh;
                     else         len_in = len_sh;
                     cnt_in = cnt_inc;
                     if (hdr_done) begin
                        cnt_in = '0;
                        len_in = hdr_len_pad;
                        if (cur_phase == PH_CHDR) begin
                           if (cur_tag == FCC_LIST) begin
                              phase_in = PH_LNAME;
                           end else begin
                              for (int i = 0; i < ARG_WORDS; i++) begin
                                 words_in[i] = '0;
                              end
                              phase_in = PH_ARGS;
                              // An empty argument chunk is interpreted at once.
                              if (hdr_len_pad == '0) begin
                                 phase_in = fin.ok ? PH_CHDR : PH_STOPPED;
                                 skind_in = fin.kind;
                                 if (fin.keep_dims) begin
                                    width_in  = '0;
                                    height_in = '0;
                                 end
                              end
                           end
                        end else if (is_video_tag) begin
                           if (too_big)                  phase_in = PH_STOPPED;
                           else if (hdr_len_pad != '0)   phase_in = PH_PAYLOAD;
                        end else if (hdr_len_pad != '0) begin
                           phase_in = PH_SKIP;
                        end
                     end
                  end
                  PH_LNAME: begin
                     len_in = len_sh;
                     cnt_in = cnt_inc;
                     if (name_done) begin
                        cnt_in   = '0;
                        phase_in = is_movi ? PH_DHDR : PH_CHDR;
                     end
                  end
                  PH_ARGS: begin
                     for (int i = 0; i < ARG_WORDS; i++) begin
                        words_in[i] = words_upd[i];
                     end
                     cnt_in = cnt_inc;
                     if (args_done) begin
                        cnt_in   = '0;
                        phase_in = fin.ok ? PH_CHDR : PH_STOPPED;
                        skind_in = fin.kind;
                        if (fin.keep_rate) begin
                           rate_in  = words_upd[6];
                           scale_in = words_upd[5];
                        end
                        if (fin.keep_dims) begin
                           width_in  = words_upd[1][15:0];
                           height_in = words_upd[2][15:0];
                        end
                     end
                  end
                  PH_PAYLOAD, PH_SKIP: begin
                     cnt_in = cnt_inc;
                     if (run_done) begin
                        cnt_in   = '0;
                        phase_in = PH_DHDR;
                     end
                  end
                  default: begin
                     phase_in = PH_STOPPED;
                  end
               endcase
            end
         end
      end
   end

   // Result word for this input word.
   always_comb begin
      res_valid_in = 1'b0;
      kind_in      = KIND_PAYLOAD;
      last_in      = 1'b0;
      pbyte_in     = '0;
      flen_in      = '0;
      status_in    = ST_EOF_HDR;
      owidth_in    = '0;
      oheight_in   = '0;
      orate_in     = '0;
      oscale_in    = '0;
      if (cur_phase != PH_STOPPED) begin
         if (eof_ff) begin
            res_valid_in = 1'b1;
            kind_in      = KIND_STOP;
            case (cur_phase)
               PH_PAYLOAD:       status_in = ST_EOF_DATA;
               PH_DHDR, PH_SKIP: status_in = ST_READ_ERR;
               default:          status_in = ST_EOF_HDR;
            endcase
         end else begin
            case (cur_phase)
               PH_RIFF: begin
                  if (riff_done && !riff_ok) begin
                     res_valid_in = 1'b1;
                     kind_in      = KIND_STOP;
                     status_in    = ST_NOT_AVI;
                  end
               end
               PH_CHDR: begin
                  if (hdr_done && (cur_tag != FCC_LIST) && (hdr_len_pad == '0) && !fin.ok) begin
                     res_valid_in = 1'b1;
                     kind_in      = KIND_STOP;
                     status_in    = ST_BAD_CODEC;
                  end
               end
               PH_DHDR: begin
                  if (hdr_done && is_video_tag && too_big) begin
                     res_valid_in = 1'b1;
                     kind_in      = KIND_STOP;
                     status_in    = ST_TOO_BIG;
                  end
               end
               PH_LNAME: begin
                  if (name_done && is_movi) begin
                     res_valid_in = 1'b1;
                     kind_in      = KIND_HEADER;
                     owidth_in    = cur_width;
                     oheight_in   = cur_height;
                     orate_in     = cur_rate;
                     oscale_in    = cur_scale;
                  end
               end
               PH_ARGS: begin
                  if (args_done && !fin.ok) begin
                     res_valid_in = 1'b1;
                     kind_in      = KIND_STOP;
                     status_in    = ST_BAD_CODEC;
                  end
               end
               PH_PAYLOAD: begin
                  res_valid_in = 1'b1;
                  kind_in      = KIND_PAYLOAD;
                  pbyte_in     = byte_ff;
                  last_in      = run_done;
                  flen_in      = cur_len;
               end
               default: begin
                  res_valid_in = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STOPPED;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
      tag_ff    <= tag_in;
      len_ff    <= len_in;
      skind_ff  <= skind_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      rate_ff   <= rate_in;
      scale_ff  <= scale_in;
      for (int i = 0; i < ARG_WORDS; i++) begin
         words_ff[i] <= words_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= res_valid_in;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (go) begin
         kind_ff    <= kind_in;
         last_ff    <= last_in;
         pbyte_ff   <= pbyte_in;
         flen_ff    <= flen_in;
         status_ff  <= status_in;
         owidth_ff  <= owidth_in;
         oheight_ff <= oheight_in;
         orate_ff   <= orate_in;
         oscale_ff  <= oscale_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {5'd0, oscale_ff, orate_ff, oheight_ff, owidth_ff, status_ff,
                        flen_ff, pbyte_ff};

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the AVI MJPEG chunk demultiplexer: builds random AVI files,
// streams them in byte by byte and checks every result word against its own parser.
// Depends on amcd_pkg and avi_mjpeg_chunk_demux_top.
`timescale 1ns / 1ps

module testbench;
   import amcd_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int ITEMS_PER_PASS = 250;
   localparam logic [31:0] FCC_AVIH = 32'h6869_7661;
   localparam logic [31:0] FCC_JUNK = 32'h4B4E_554A;

   typedef struct packed {
      logic        new_file;
      logic [7:0]  file_byte;
      logic        end_of_file;
   } file_word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload;
      logic        last;
      logic [31:0] flen;
      logic [2:0]  status;
      logic [15:0] width;
      logic [15:0] height;
      logic [31:0] rate;
      logic [31:0] scale;
   } demux_result_type;

   // Tracks the parser state and holds the result words still to come.
   class frame_scoreboard;
      phase_type        phase;
      logic [31:0]      byte_cnt;
      logic [31:0]      tag;
      logic [31:0]      chunk_len;
      logic [31:0]      max_len;
      logic [31:0]      args [ARG_WORDS];
      logic [1:0]       stream;
      logic [15:0]      width;
      logic [15:0]      height;
      logic [31:0]      rate;
      logic [31:0]      scale;
      demux_result_type expected_q [$];
      int               errors;

      function new();
         max_len = MAX_FRAME_RESET;
         errors  = 0;
         restart();
      endfunction

      function void restart();
         phase     = PH_STOPPED;
         byte_cnt  = '0;
         tag       = '0;
         chunk_len = '0;
         foreach (args[i]) args[i] = '0;
         stream    = SK_OTHER;
         width     = '0;
         height    = '0;
         rate      = '0;
         scale     = '0;
      endfunction

      function void set_limit(logic [31:0] v);
         max_len = v;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void emit_stop(logic [2:0] code);
         demux_result_type r;
         r        = '0;
         r.kind   = KIND_STOP;
         r.status = code;
         phase    = PH_STOPPED;
         byte_cnt = '0;
         expected_q.push_back(r);
      endfunction

      function bit handler_ok(logic [31:0] c);
         return c == FCC_MJPG_U || c == FCC_MJPG_L || c == FCC_MSVC_U || c == FCC_MSVC_L;
      endfunction

      // Applies a completed strh/strf chunk; returns 0 when the codec is rejected.
      function bit close_args();
         phase    = PH_CHDR;
         byte_cnt = '0;
         if (tag == FCC_STRH) begin
            if (args[0] == FCC_VIDS) begin
               if (!handler_ok(args[1])) return 1'b0;
               rate   = args[6];
               scale  = args[5];
               stream = SK_VIDEO;
            end else if (args[0] == FCC_AUDS) begin
               stream = SK_AUDIO;
            end
         end else if (tag == FCC_STRF) begin
            if (stream == SK_VIDEO) begin
               width  = args[1][15:0];
               height = args[2][15:0];
               if (!(handler_ok(args[4]) || args[4] == FCC_CRAM_U || args[4] == FCC_CRAM_L))
                  return 1'b0;
            end
         end else begin
            stream = SK_OTHER;
         end
         return 1'b1;
      endfunction

      function void note_input(logic nf, logic [7:0] b, logic eof);
         demux_result_type r;
         if (nf) begin
            restart();
            phase = PH_RIFF;
         end
         if (phase == PH_STOPPED) return;
         if (eof) begin
            if (phase == PH_PAYLOAD) emit_stop(ST_EOF_DATA);
            else if (phase == PH_DHDR || phase == PH_SKIP) emit_stop(ST_READ_ERR);
            else emit_stop(ST_EOF_HDR);
            return;
         end
         case (phase)
            PH_RIFF: begin
               if (byte_cnt < 4) tag = {b, tag[31:8]};
               else chunk_len = {b, chunk_len[31:8]};
               byte_cnt++;
               if (byte_cnt == RIFF_HDR_BYTES) begin
                  if (tag != FCC_RIFF || chunk_len != FCC_AVI) begin
                     emit_stop(ST_NOT_AVI);
                  end else begin
                     phase    = PH_CHDR;
                     byte_cnt = '0;
                  end
               end
            end
            PH_CHDR, PH_DHDR: begin
               if (byte_cnt < 4) tag = {b, tag[31:8]};
               else chunk_len = {b, chunk_len[31:8]};
               byte_cnt++;
               if (byte_cnt == 8) begin
                  byte_cnt = '0;
                  // Odd lengths are padded to even, but the all-ones length saturates.
                  if (chunk_len[0] && chunk_len != '1) chunk_len++;
                  if (phase == PH_CHDR) begin
                     if (tag == FCC_LIST) begin
                        phase = PH_LNAME;
                     end else begin
                        foreach (args[i]) args[i] = '0;
                        phase = PH_ARGS;
                        if (chunk_len == 0 && !close_args()) emit_stop(ST_BAD_CODEC);
                     end
                  end else if (tag == FCC_00DB || tag == FCC_00DC) begin
                     if (chunk_len > max_len) emit_stop(ST_TOO_BIG);
                     else if (chunk_len != 0) phase = PH_PAYLOAD;
                  end else if (chunk_len != 0) begin
                     phase = PH_SKIP;
                  end
               end
            end
            PH_LNAME: begin
               chunk_len = {b, chunk_len[31:8]};
               byte_cnt++;
               if (byte_cnt == 4) begin
                  byte_cnt = '0;
                  if (chunk_len == FCC_MOVI) begin
                     phase    = PH_DHDR;
                     r        = '0;
                     r.kind   = KIND_HEADER;
                     r.width  = width;
                     r.height = height;
                     r.rate   = rate;
                     r.scale  = scale;
                     expected_q.push_back(r);
                  end else begin
                     phase = PH_CHDR;
                  end
               end
            end
            PH_ARGS: begin
               if (byte_cnt < KEPT_ARG_BYTES)
                  args[byte_cnt[4:2]] |= {24'd0, b} << (8 * byte_cnt[1:0]);
               byte_cnt++;
               if (byte_cnt == chunk_len && !close_args()) emit_stop(ST_BAD_CODEC);
            end
            PH_PAYLOAD: begin
               byte_cnt++;
               r         = '0;
               r.kind    = KIND_PAYLOAD;
               r.payload = b;
               r.flen    = chunk_len;
               r.last    = (byte_cnt == chunk_len);
               if (r.last) begin
                  phase    = PH_DHDR;
                  byte_cnt = '0;
               end
               expected_q.push_back(r);
            end
            PH_SKIP: begin
               byte_cnt++;
               if (byte_cnt == chunk_len) begin
                  phase    = PH_DHDR;
                  byte_cnt = '0;
               end
            end
            default: phase = PH_STOPPED;
         endcase
      endfunction

      function void compare_field(string what, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
         end
      endfunction

      function void check_result(logic [1:0] kind, logic [RSP_DATA_BITS-1:0] d, logic last);
         demux_result_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result word expected none, got kind %0h data %0h", $time, kind, d);
            return;
         end
         e = expected_q.pop_front();
         compare_field("result_kind", 32'(e.kind), 32'(kind));
         compare_field("payload_byte", 32'(e.payload), 32'(d[7:0]));
         compare_field("last_of_frame", 32'(e.last), 32'(last));
         compare_field("frame_length", e.flen, d[39:8]);
         compare_field("status_code", 32'(e.status), 32'(d[42:40]));
         compare_field("frame_width", 32'(e.width), 32'(d[58:43]));
         compare_field("frame_height", 32'(e.height), 32'(d[74:59]));
         compare_field("rate_value", e.rate, d[106:75]);
         compare_field("scale_value", e.scale, d[138:107]);
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [31:0]              csr_data;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [7:0]               req_tdata;
   logic                     req_tuser;
   logic                     req_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [1:0]               rsp_tuser;
   logic                     rsp_tlast;

   frame_scoreboard sb = new();
   file_word_type   stim [$];
   bit              no_gaps = 1'b0;
   int              cycles  = 0;

   avi_mjpeg_chunk_demux_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready = no_gaps || ($urandom_range(0, 99) >= 12);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   function automatic bit take_gap();
      return !no_gaps && ($urandom_range(0, 99) < 12);
   endfunction

   function automatic void put_item(logic nf, logic [7:0] b, logic eof);
      file_word_type s;
      s.new_file    = nf;
      s.file_byte   = b;
      s.end_of_file = eof;
      stim.push_back(s);
   endfunction

   function automatic void put_byte(logic [7:0] b);
      put_item(stim.size() == 0, b, 1'b0);
   endfunction

   function automatic void put_word(logic [31:0] w);
      for (int i = 0; i < 4; i++) put_byte(w[8*i +: 8]);
   endfunction

   // Header chunk whose first bytes carry the given little-endian words.
   function automatic void put_arg_chunk(logic [31:0] tag, logic [31:0] w [ARG_WORDS],
                                         logic [31:0] n);
      logic [31:0] padded;
      padded = n + n[0];
      put_word(tag);
      put_word(n);
      for (int i = 0; i < padded; i++)
         put_byte(i < 28 ? w[i/4][8*(i%4) +: 8] : 8'($urandom));
   endfunction

   function automatic logic [31:0] pick_codec(bit good, bit cram_ok);
      logic [31:0] ok_list [6] = '{FCC_MJPG_U, FCC_MJPG_L, FCC_MSVC_U, FCC_MSVC_L,
                                   FCC_CRAM_U, FCC_CRAM_L};
      if (!good) return (!cram_ok && $urandom_range(0, 1)) ? FCC_CRAM_L : $urandom;
      return ok_list[$urandom_range(0, cram_ok ? 5 : 3)];
   endfunction

   // Builds one AVI file, mostly well formed, with a random ending.
   function automatic void build_file(logic [31:0] limit);
      int          r;
      int          k;
      logic [31:0] len;
      logic [31:0] w [ARG_WORDS];
      stim.delete();
      r = $urandom_range(0, 99);
      if (r < 5) begin
         repeat ($urandom_range(1, 20)) put_byte(8'($urandom));
      end else begin
         put_word(r < 9 ? $urandom : FCC_RIFF);
         put_word($urandom);
         put_word((r >= 9 && r < 12) ? $urandom : FCC_AVI);
         put_word(FCC_LIST);
         put_word($urandom);
         put_word($urandom);
         foreach (w[i]) w[i] = $urandom;
         put_arg_chunk(FCC_AVIH, w, $urandom_range(0, 21));
         repeat ($urandom_range(1, 2)) begin
            put_word(FCC_LIST);
            put_word($urandom);
            put_word($urandom);
            foreach (w[i]) w[i] = $urandom;
            k = $urandom_range(0, 99);
            w[0] = k < 60 ? FCC_VIDS : (k < 85 ? FCC_AUDS : $urandom);
            w[1] = pick_codec($urandom_range(0, 99) < 90, 1'b0);
            if ($urandom_range(0, 7) == 0) w[5] = '0;
            k = $urandom_range(0, 99);
            len = k < 85 ? $urandom_range(28, 40) : (k < 95 ? $urandom_range(0, 27)
                                                            : $urandom_range(250, 270));
            put_arg_chunk(FCC_STRH, w, len);
            // A chunk between strh and strf drops the video mark.
            if ($urandom_range(0, 9) == 0) put_arg_chunk(FCC_JUNK, w, $urandom_range(0, 9));
            foreach (w[i]) w[i] = $urandom;
            w[0] = 32'd40;
            w[4] = pick_codec($urandom_range(0, 99) < 90, 1'b1);
            put_arg_chunk(FCC_STRF, w, $urandom_range(0, 9) == 0 ? $urandom_range(0, 19)
                                                                 : $urandom_range(20, 44));
         end
         put_word(FCC_LIST);
         put_word($urandom);
         put_word(FCC_MOVI);
         repeat ($urandom_range(1, 8)) begin
            k = $urandom_range(0, 99);
            if (k < 65) begin
               put_word($urandom_range(0, 1) ? FCC_00DB : FCC_00DC);
               len = k < 5 ? 32'd0 : $urandom_range(1, 25);
            end else if (k < 85) begin
               put_word($urandom);
               len = $urandom_range(0, 12);
            end else if (k < 90) begin
               put_word(FCC_LIST);
               len = 32'd4;
            end else begin
               // Oversized or all-ones length: a few bytes follow and the file ends.
               put_word($urandom_range(0, 1) ? FCC_00DB : FCC_00DC);
               put_word((k < 95 && limit != '1) ? limit + 32'd1 : 32'hFFFF_FFFF);
               repeat ($urandom_range(0, 6)) put_byte(8'($urandom));
               break;
            end
            put_word(len);
            repeat (len + len[0]) put_byte(8'($urandom));
         end
      end
      r = $urandom_range(0, 99);
      if (r < 20 && stim.size() > 1) begin
         k = $urandom_range(1, stim.size() - 1);
         while (stim.size() > k) void'(stim.pop_back());
      end
      if (r < 92) put_item(1'b0, 8'($urandom), 1'b1);
      if (r >= 85 && r < 92)
         repeat ($urandom_range(1, 3)) put_item(1'b0, 8'($urandom), 1'($urandom));
   endfunction

   // Called at a falling edge; returns at a falling edge.
   task automatic send_item(input file_word_type it);
      while (take_gap()) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = it.file_byte;
      req_tuser  = it.new_file;
      req_tlast  = it.end_of_file;
      do @(posedge clock); while (!req_tready);
      sb.note_input(it.new_file, it.file_byte, it.end_of_file);
      @(negedge clock);
   endtask

   task automatic send_all();
      foreach (stim[i]) send_item(stim[i]);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_limit(input logic [31:0] v);
      csr_valid = 1'b1;
      csr_data  = v;
      do @(posedge clock); while (!csr_ready);
      sb.set_limit(v);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      logic [31:0] limits [5];
      int          sent;
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      limits = '{MAX_FRAME_RESET, 32'd0, 32'hFFFF_FFFF, $urandom_range(2, 30), MAX_FRAME_RESET};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Words before any new_file are ignored, then a new file that is only an end mark,
      // an end mark right after the first byte, and a twelve-byte header that is not AVI.
      stim.delete();
      put_item(1'b0, 8'hA5, 1'b0);
      put_item(1'b0, 8'h00, 1'b1);
      put_item(1'b1, 8'hFF, 1'b1);
      put_item(1'b1, 8'h52, 1'b0);
      put_item(1'b0, 8'h00, 1'b1);
      put_item(1'b1, 8'hFF, 1'b0);
      repeat (11) put_item(1'b0, 8'hFF, 1'b0);
      send_all();
      drain();

      for (int pass = 0; pass < 5; pass++) begin
         no_gaps = (pass == 2);
         if (pass > 0) write_limit(limits[pass]);
         sent = 0;
         while (sent < ITEMS_PER_PASS) begin
            build_file(limits[pass]);
            send_all();
            sent += stim.size();
         end
         drain();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: avi_mjpeg_chunk_demux_top.f
hw/rtl/amcd_pkg.sv
hw/rtl/avi_mjpeg_chunk_demux_top.sv
tb/sv/testbench.sv
